// ----- hw/rtl/ssc_pkg.sv -----
// Shared constants and types for the sparse set component store.
// Field widths, operation and status codes, and the sparse table size.
// No dependencies.
package ssc_pkg;

  localparam int IDX_W        = 10;
  localparam int GEN_W        = 32;
  localparam int VAL_FIELD_W  = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int SPARSE_DEPTH = 1 << IDX_W;

  localparam int DEF_MAX_ENTITIES = 1024;
  localparam int DEF_VALUE_BITS   = 32;

  // operation codes; the unused code behaves as a lookup
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } owner_t;

endpackage

// ----- hw/rtl/sparse_set_component_store_unit.sv -----
// Sparse set component store: entity handle to component value map.
// Holds the sparse table and the dense owner/value tables as on-chip memories.
// Depends on ssc_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into unit | in_valid/in_stall  | mode, handle_index, entity_generation, value
//  out     | from unit | out_valid/out_stall| status, found, read_value, live_count
//
// Steps: every operation goes through sparse read (S_IDLE), dense read (S_LOOK),
// then compare and commit (S_EXEC), where its result beat is registered. The
// input reopens when the state returns to S_IDLE; a remove that moves the last entry
// down takes an extra S_FIX step (the second sparse write). One operation is in flight at a time.
// Reset: after rst the sparse table is swept to "no slot", one entry a cycle,
// all SPARSE_DEPTH (1024) entries, with in_stall held high throughout.
// Stalls: the result register frees the input side; an operation waits at its
// commit step only while a previous result is still stalled on the output.
module sparse_set_component_store_unit
  import ssc_pkg::*;
#(
  parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
  parameter int VALUE_BITS   = DEF_VALUE_BITS,
  localparam int DENSE_AW    = $clog2(MAX_ENTITIES),
  localparam int CNT_W       = $clog2(MAX_ENTITIES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MODE_W-1:0]      mode,
  input  logic [IDX_W-1:0]       handle_index,
  input  logic [GEN_W-1:0]       entity_generation,
  input  logic [VAL_FIELD_W-1:0] value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic                   found,
  output logic [VAL_FIELD_W-1:0] read_value,
  output logic [CNT_W-1:0]       live_count
);

  // sparse entries carry one extra bit so that all ones never names a slot
  localparam int SLOT_W = DENSE_AW + 1;
  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;
  localparam int WIDE_W = (VALUE_BITS > VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;

  // ---------------------------------------------------------------- memories
  logic [SLOT_W-1:0]     sparse_mem [SPARSE_DEPTH];
  owner_t                owner_mem  [MAX_ENTITIES];
  logic [VALUE_BITS-1:0] value_mem  [MAX_ENTITIES];

  logic                  sp_we, sp_re;
  logic [IDX_W-1:0]      sp_waddr, sp_raddr;
  logic [SLOT_W-1:0]     sp_wdata, sp_rdata;

  logic                  dn_we, dn_re_a, dn_re_b;
  logic [DENSE_AW-1:0]   dn_waddr, dn_raddr_a, dn_raddr_b;
  owner_t                dn_wowner, own_a, own_b;
  logic [VALUE_BITS-1:0] dn_wvalue, val_a, val_b;

  always_ff @(posedge clk) begin
    if (sp_we) sparse_mem[sp_waddr] <= sp_wdata;
    if (sp_re) sp_rdata <= sparse_mem[sp_raddr];
  end

  always_ff @(posedge clk) begin
    if (dn_we) begin
      owner_mem[dn_waddr] <= dn_wowner;
      value_mem[dn_waddr] <= dn_wvalue;
    end
    if (dn_re_a) begin
      own_a <= owner_mem[dn_raddr_a];
      val_a <= value_mem[dn_raddr_a];
    end
    if (dn_re_b) begin
      own_b <= owner_mem[dn_raddr_b];
      val_b <= value_mem[dn_raddr_b];
    end
  end

  // ------------------------------------------------------------ control state
  logic [2:0]            state, state_next;
  logic [IDX_W-1:0]      clr_addr;
  logic [CNT_W-1:0]      count, count_next;

  // held request
  logic [MODE_W-1:0]     mode_q;
  logic [IDX_W-1:0]      idx_q;
  logic [GEN_W-1:0]      gen_q;
  logic [VALUE_BITS-1:0] val_q;

  // result register
  logic                  res_load;
  logic [STATUS_W-1:0]   res_status;
  logic [VALUE_BITS-1:0] res_value;

  logic [WIDE_W-1:0]     wide_in, wide_rd;
  logic [CNT_W-1:0]      count_m1;
  logic                  accept, out_free;
  logic                  slot_ok, present, slot_is_last, store_full;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // keep the low VALUE_BITS of the input value
  assign wide_in  = WIDE_W'(value);
  assign count_m1 = count - CNT_W'(1);

  // presence check once the dense read of the named slot is back
  assign slot_ok      = sp_rdata < SLOT_W'(count);
  assign present      = slot_ok && (own_a.idx == idx_q) && (own_a.gen == gen_q);
  assign slot_is_last = (sp_rdata == SLOT_W'(count_m1));
  assign store_full   = (count == CNT_W'(MAX_ENTITIES));

  always_comb begin
    state_next = state;
    count_next = count;
    sp_we      = 1'b0;
    sp_waddr   = idx_q;
    sp_wdata   = SLOT_NONE;
    sp_re      = 1'b0;
    sp_raddr   = handle_index;
    dn_we      = 1'b0;
    dn_waddr   = count[DENSE_AW-1:0];
    dn_wowner  = '{idx: idx_q, gen: gen_q};
    dn_wvalue  = val_q;
    dn_re_a    = 1'b0;
    dn_raddr_a = sp_rdata[DENSE_AW-1:0];
    dn_re_b    = 1'b0;
    dn_raddr_b = count_m1[DENSE_AW-1:0];
    res_load   = 1'b0;
    res_status = ST_OK;
    res_value  = '0;

    case (state)
      S_CLEAR: begin
        // sweep the sparse table to "no slot"
        sp_we    = 1'b1;
        sp_waddr = clr_addr;
        sp_wdata = SLOT_NONE;
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        // fetch the sparse entry and, in parallel, the last dense entry
        if (accept) begin
          sp_re      = 1'b1;
          dn_re_b    = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        dn_re_a    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // commit only when the result register can take the beat
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (mode_q)
            MODE_INSERT: begin
              if (present) begin
                res_status = ST_PRESENT;
              end else if (store_full) begin
                res_status = ST_FULL;
              end else begin
                dn_we      = 1'b1;
                sp_we      = 1'b1;
                sp_waddr   = idx_q;
                sp_wdata   = SLOT_W'(count);
                count_next = count + CNT_W'(1);
              end
            end
            MODE_REMOVE: begin
              if (!present) begin
                res_status = ST_NOT_PRESENT;
              end else begin
                count_next = count_m1;
                sp_we      = 1'b1;
                if (slot_is_last) begin
                  sp_waddr = idx_q;
                  sp_wdata = SLOT_NONE;
                end else begin
                  // move the last entry down and repoint it, drop idx next
                  dn_we      = 1'b1;
                  dn_waddr   = sp_rdata[DENSE_AW-1:0];
                  dn_wowner  = own_b;
                  dn_wvalue  = val_b;
                  sp_waddr   = own_b.idx;
                  sp_wdata   = sp_rdata;
                  state_next = S_FIX;
                end
              end
            end
            default: begin
              if (present) res_value  = val_a;
              else         res_status = ST_NOT_PRESENT;
            end
          endcase
        end
      end
      S_FIX: begin
        sp_we      = 1'b1;
        sp_waddr   = idx_q;
        sp_wdata   = SLOT_NONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + IDX_W'(1);
      if (res_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      idx_q  <= handle_index;
      gen_q  <= entity_generation;
      val_q  <= wide_in[VALUE_BITS-1:0];
    end
    if (res_load) begin
      status     <= res_status;
      found      <= present;
      wide_rd    <= WIDE_W'(res_value);
      live_count <= count_next;
    end
  end

  assign read_value = wide_rd[VAL_FIELD_W-1:0];

endmodule
